### hdl/bcso_pkg.sv
package bcso_pkg;

    // Field widths
    localparam int IN_W      = 32;               // input coordinate field
    localparam int COORD_W   = 32;               // bits of each coordinate that are used
    localparam int MAT_W     = 32;               // Q8.24 matrix entry
    localparam int CTR_W     = COORD_W + 1;      // doubled center / extent
    localparam int PROD_W    = MAT_W + CTR_W;    // entry times doubled coordinate
    localparam int SUM_W     = PROD_W + 2;       // three products plus translation
    localparam int CMP_W     = SUM_W + 2;        // clip +/- extent + w
    localparam int TRANS_SH  = 13;               // Q.24 to doubled Q.36

    localparam int N_AXES    = 3;
    localparam int N_ROWS    = 4;
    localparam int N_ENTRIES = 16;
    localparam int N_PAIRS   = N_ENTRIES / 2;
    localparam int CFG_W     = 2 * MAT_W;
    localparam int CFG_IDX_W = $clog2(N_PAIRS);

    typedef logic signed [MAT_W-1:0]  t_entry;
    typedef logic signed [CTR_W-1:0]  t_ctr;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [CMP_W-1:0]  t_cmp;

    // Identity matrix, two entries per register
    localparam logic [CFG_W-1:0] MAT_RESET [N_PAIRS] = '{
        64'h0000_0000_0100_0000,
        64'h0000_0000_0000_0000,
        64'h0100_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0100_0000,
        64'h0000_0000_0000_0000,
        64'h0100_0000_0000_0000
    };

endpackage

### hdl/bcso_box_if.sv
interface bcso_box_if
    import bcso_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] min_x;
    logic signed [IN_W-1:0] min_y;
    logic signed [IN_W-1:0] min_z;
    logic signed [IN_W-1:0] max_x;
    logic signed [IN_W-1:0] max_y;
    logic signed [IN_W-1:0] max_z;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

### hdl/bcso_hit_if.sv
interface bcso_hit_if;
    logic valid;
    logic ready;
    logic overlaps;

    modport source (output valid, overlaps, input ready);
    modport sink   (input valid, overlaps, output ready);
endinterface

### hdl/box_clip_space_overlap_test_top.sv
// Channel   Dir  Transfer when          Payload
// i_box     in   valid & ready          min_x..max_z, signed Q20.12
// o_hit     out  valid & ready          overlaps
// i_cfg     in   i_cfg_we               i_cfg_idx (pair 0..7), i_cfg_data
//
// One box per cycle sustained while o_hit is not stalled.
// Stages: center/extent, products (21 multipliers, the deepest stage), row sums,
// clip compare into the output register.
// Synchronous active-low reset clears the valid bits and loads the identity matrix.
// Each stage holds while the next is full and stalled; empty stages are filled over.
module box_clip_space_overlap_test_top
    import bcso_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bcso_box_if.sink             i_box,
    bcso_hit_if.source           o_hit,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_mat [N_PAIRS];

    t_entry          w_m   [N_ENTRIES];
    logic [MAT_W-1:0] w_ma [N_ENTRIES];

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    t_ctr   n_ctr [N_AXES];
    t_ctr   n_ext [N_AXES];
    t_ctr   r_ctr [N_AXES];
    t_ctr   r_ext [N_AXES];

    t_prod  n_pc  [N_ROWS][N_AXES];
    t_prod  n_pe  [N_AXES][N_AXES];
    t_prod  r_pc  [N_ROWS][N_AXES];
    t_prod  r_pe  [N_AXES][N_AXES];
    t_entry r_tr  [N_ROWS];

    t_sum   n_clip [N_ROWS];
    t_sum   n_esum [N_AXES];
    t_sum   r_clip [N_ROWS];
    t_sum   r_esum [N_AXES];

    logic   n_hit;
    logic   r_hit;

    logic signed [IN_W-1:0] w_lo [N_AXES];
    logic signed [IN_W-1:0] w_hi [N_AXES];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < N_PAIRS; p++) begin
                r_mat[p] <= MAT_RESET[p];
            end
        end else if (i_cfg_we) begin
            r_mat[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int i = 0; i < N_ENTRIES; i++) begin
            w_m[i]  = r_mat[i / 2][(i % 2) * MAT_W +: MAT_W];
            w_ma[i] = w_m[i][MAT_W-1] ? MAT_W'(-w_m[i]) : MAT_W'(w_m[i]);
        end
    end

    // Handshake: a stage takes new data when empty or when its successor moves
    assign w_rdy4      = !r_v4 || o_hit.ready;
    assign w_rdy3      = !r_v3 || w_rdy4;
    assign w_rdy2      = !r_v2 || w_rdy3;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign i_box.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_box.valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stage 1: doubled center and extent
    assign w_lo[0] = i_box.min_x;
    assign w_lo[1] = i_box.min_y;
    assign w_lo[2] = i_box.min_z;
    assign w_hi[0] = i_box.max_x;
    assign w_hi[1] = i_box.max_y;
    assign w_hi[2] = i_box.max_z;

    always_comb begin
        for (int k = 0; k < N_AXES; k++) begin
            n_ctr[k] = CTR_W'($signed(w_lo[k][COORD_W-1:0]))
                     + CTR_W'($signed(w_hi[k][COORD_W-1:0]));
            n_ext[k] = CTR_W'($signed(w_hi[k][COORD_W-1:0]))
                     - CTR_W'($signed(w_lo[k][COORD_W-1:0]));
        end
    end

    // Stage 2: products; entry index is column * 4 + row
    always_comb begin
        for (int r = 0; r < N_ROWS; r++) begin
            for (int k = 0; k < N_AXES; k++) begin
                n_pc[r][k] = w_m[N_ROWS * k + r] * r_ctr[k];
            end
        end
        for (int r = 0; r < N_AXES; r++) begin
            for (int k = 0; k < N_AXES; k++) begin
                n_pe[r][k] = $signed({1'b0, w_ma[N_ROWS * k + r]}) * r_ext[k];
            end
        end
    end

    // Stage 3: row sums, translation aligned to doubled Q.36
    always_comb begin
        for (int r = 0; r < N_ROWS; r++) begin
            n_clip[r] = {{(SUM_W - MAT_W - TRANS_SH){r_tr[r][MAT_W-1]}},
                         r_tr[r], {TRANS_SH{1'b0}}}
                      + SUM_W'(r_pc[r][0]) + SUM_W'(r_pc[r][1]) + SUM_W'(r_pc[r][2]);
        end
        for (int r = 0; r < N_AXES; r++) begin
            n_esum[r] = SUM_W'(r_pe[r][0]) + SUM_W'(r_pe[r][1]) + SUM_W'(r_pe[r][2]);
        end
    end

    // Stage 4: inclusive clip bounds on x, y, z
    always_comb begin
        t_cmp a;
        t_cmp b;
        n_hit = 1'b1;
        for (int r = 0; r < N_AXES; r++) begin
            a = CMP_W'(r_clip[3]) + CMP_W'(r_esum[r]) + CMP_W'(r_clip[r]);
            b = CMP_W'(r_clip[3]) + CMP_W'(r_esum[r]) - CMP_W'(r_clip[r]);
            if (a[CMP_W-1] || b[CMP_W-1]) begin
                n_hit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_box.valid) begin
            r_ctr <= n_ctr;
            r_ext <= n_ext;
        end
        if (w_rdy2 && r_v1) begin
            r_pc <= n_pc;
            r_pe <= n_pe;
            for (int r = 0; r < N_ROWS; r++) begin
                r_tr[r] <= w_m[3 * N_ROWS + r];
            end
        end
        if (w_rdy3 && r_v2) begin
            r_clip <= n_clip;
            r_esum <= n_esum;
        end
        if (w_rdy4 && r_v3) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit.valid    = r_v4;
    assign o_hit.overlaps = r_hit;

endmodule

### hdl/bcso_checker.sv
module bcso_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_overlaps
);

    localparam logic [2:0] MAX_FLIGHT = 3'd4;

    logic [2:0] r_cnt;
    logic       w_in_xfer;
    logic       w_out_xfer;

    assign w_in_xfer  = i_in_valid && i_in_ready;
    assign w_out_xfer = i_out_valid && i_out_ready;

    // Boxes accepted and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_xfer && !w_out_xfer) begin
            r_cnt <= r_cnt + 3'd1;
        end else if (!w_in_xfer && w_out_xfer) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_overlaps))
        else $error("stalled result changed");

    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= MAX_FLIGHT) && (!i_out_valid || r_cnt != 3'd0))
        else $error("results lost or invented");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

endmodule

bind box_clip_space_overlap_test_top bcso_checker u_bcso_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_box.valid),
    .i_in_ready  (i_box.ready),
    .i_out_valid (o_hit.valid),
    .i_out_ready (o_hit.ready),
    .i_overlaps  (o_hit.overlaps)
);
